// ===== hdl/rfr_pkg.sv =====
package rfr_pkg;

    localparam int BUFFER_DEPTH = 16384;

    localparam int DATA_W      = 8;
    localparam int FRAG_LEN_W  = 14;
    localparam int FRAME_LEN_W = 15;
    localparam int ADDR_W      = 14;
    localparam int STORED_W    = 16;
    localparam int SUM_W       = 17;
    localparam int CRC_W       = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 15;
    localparam int ACT_W       = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAGMENT_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN    = 1'b1;

    localparam logic [FRAG_LEN_W-1:0]  MAX_FRAGMENT_LEN_RESET = 14'd2048;
    localparam logic [FRAME_LEN_W-1:0] MAX_FRAME_LEN_RESET    = 15'd9000;

    localparam logic [FRAG_LEN_W-1:0]  BYTE_INDEX_MAX = 14'd16383;
    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_SAT  = 15'h7fff;
    localparam logic [CRC_W-1:0]       CRC_PRESET     = 32'hffff_ffff;
    localparam logic [CRC_W-1:0]       CRC_POLY       = 32'hedb8_8320;

    // per-fragment action, chosen on the first item of a fragment
    localparam logic [ACT_W-1:0] ACT_NONE      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_IGNORE    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SKIP      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_START     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_START_END = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CONT      = 3'd5;
    localparam logic [ACT_W-1:0] ACT_END       = 3'd6;
    localparam logic [ACT_W-1:0] ACT_END_DROP  = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0]     data_byte;
        logic                  byte_present;
        logic                  last_byte;
        logic                  flag_start;
        logic                  flag_cont;
        logic                  flag_end;
        logic [FRAG_LEN_W-1:0] frag_len;
        logic [CRC_W-1:0]      expected_crc;
    } in_item_t;

    typedef struct packed {
        logic                   write_enable;
        logic [ADDR_W-1:0]      write_address;
        logic [DATA_W-1:0]      write_data;
        logic                   fragment_done;
        logic                   crc_error;
        logic                   length_error;
        logic                   overflow_drop;
        logic                   frame_ready;
        logic [FRAME_LEN_W-1:0] frame_length;
    } out_item_t;

    // classified item handed from the front to the back
    typedef struct packed {
        logic                   write_enable;
        logic [ADDR_W-1:0]      write_address;
        logic [DATA_W-1:0]      crc_data;
        logic                   crc_update;
        logic                   fragment_done;
        logic                   crc_check;
        logic [CRC_W-1:0]       expected_crc;
        logic                   length_error;
        logic                   overflow_drop;
        logic                   frame_ready;
        logic [FRAME_LEN_W-1:0] frame_length;
    } work_t;

    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [DATA_W-1:0] data
    );
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {{(CRC_W-DATA_W){1'b0}}, data};
        for (int k = 0; k < DATA_W; k++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

endpackage

// ===== hdl/rfr_front.sv =====
module rfr_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  rfr_pkg::in_item_t                   in_data,
    input  logic                                cfg_write,
    input  logic [rfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rfr_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                push_valid,
    input  logic                                push_ready,
    output rfr_pkg::work_t                      push_data
);

    logic [rfr_pkg::FRAG_LEN_W-1:0]  max_frag_reg;
    logic [rfr_pkg::FRAME_LEN_W-1:0] max_frame_reg;

    logic                             open_reg,   open_next;
    logic [rfr_pkg::STORED_W-1:0]     stored_reg, stored_next;
    logic [rfr_pkg::FRAG_LEN_W-1:0]   idx_reg,    idx_next;
    logic [rfr_pkg::ACT_W-1:0]        act_reg,    act_next;
    logic [rfr_pkg::STORED_W-1:0]     base_reg,   base_next;

    logic [rfr_pkg::ACT_W-1:0]        act;
    logic [rfr_pkg::STORED_W-1:0]     base;
    logic [rfr_pkg::FRAG_LEN_W-1:0]   idx;
    logic [rfr_pkg::SUM_W-1:0]        end_sum;
    logic [rfr_pkg::SUM_W-1:0]        addr;
    logic [rfr_pkg::SUM_W-1:0]        total;
    logic                             byte_ok;
    logic                             writable;
    logic                             accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    always_comb
    begin
        end_sum = {1'b0, stored_reg} + {{(rfr_pkg::SUM_W-rfr_pkg::FRAG_LEN_W){1'b0}},
                                        in_data.frag_len};
        act  = act_reg;
        base = base_reg;
        idx  = idx_reg;
        if (act_reg == rfr_pkg::ACT_NONE)
        begin
            base = '0;
            idx  = '0;
            if (in_data.frag_len > max_frag_reg)
            begin
                act = rfr_pkg::ACT_IGNORE;
            end
            else if (in_data.flag_start)
            begin
                act = in_data.flag_end ? rfr_pkg::ACT_START_END : rfr_pkg::ACT_START;
            end
            else if (open_reg && in_data.flag_end)
            begin
                base = stored_reg;
                act  = (end_sum > {2'b00, max_frame_reg}) ? rfr_pkg::ACT_END_DROP
                                                          : rfr_pkg::ACT_END;
            end
            else if (open_reg && in_data.flag_cont)
            begin
                base = stored_reg;
                act  = rfr_pkg::ACT_CONT;
            end
            else
            begin
                act = rfr_pkg::ACT_SKIP;
            end
        end

        addr  = {1'b0, base} + {{(rfr_pkg::SUM_W-rfr_pkg::FRAG_LEN_W){1'b0}}, idx};
        total = {1'b0, base} + {{(rfr_pkg::SUM_W-rfr_pkg::FRAG_LEN_W){1'b0}},
                                in_data.frag_len};

        byte_ok  = in_data.byte_present && (act != rfr_pkg::ACT_IGNORE)
                   && (idx < in_data.frag_len);
        writable = (act == rfr_pkg::ACT_START) || (act == rfr_pkg::ACT_START_END)
                   || (act == rfr_pkg::ACT_CONT) || (act == rfr_pkg::ACT_END);

        push_data               = '0;
        push_data.write_enable  = byte_ok && writable
                                  && (addr < rfr_pkg::SUM_W'(rfr_pkg::BUFFER_DEPTH));
        push_data.write_address = push_data.write_enable ? addr[rfr_pkg::ADDR_W-1:0] : '0;
        push_data.crc_data      = in_data.data_byte;
        push_data.crc_update    = byte_ok;
        push_data.fragment_done = in_data.last_byte;
        push_data.expected_crc  = in_data.expected_crc;

        open_next   = open_reg;
        stored_next = stored_reg;
        act_next    = act;
        base_next   = base;
        idx_next    = (in_data.byte_present && (idx < rfr_pkg::BYTE_INDEX_MAX))
                      ? idx + 1'b1 : idx;

        if (in_data.last_byte)
        begin
            act_next  = rfr_pkg::ACT_NONE;
            base_next = '0;
            idx_next  = '0;
            push_data.length_error = (act == rfr_pkg::ACT_IGNORE);
            push_data.crc_check    = (act != rfr_pkg::ACT_IGNORE);
            unique case (act)
                rfr_pkg::ACT_SKIP:
                begin
                    if (!open_reg)
                    begin
                        stored_next = '0;
                    end
                end
                rfr_pkg::ACT_START:
                begin
                    open_next   = 1'b1;
                    stored_next = {{(rfr_pkg::STORED_W-rfr_pkg::FRAG_LEN_W){1'b0}},
                                   in_data.frag_len};
                end
                rfr_pkg::ACT_START_END:
                begin
                    push_data.frame_ready  = 1'b1;
                    push_data.frame_length = {1'b0, in_data.frag_len};
                    open_next   = 1'b0;
                    stored_next = '0;
                end
                rfr_pkg::ACT_CONT:
                begin
                    if (total >= {2'b00, max_frame_reg})
                    begin
                        push_data.overflow_drop = 1'b1;
                        open_next   = 1'b0;
                        stored_next = '0;
                    end
                    else
                    begin
                        stored_next = total[rfr_pkg::STORED_W-1:0];
                    end
                end
                rfr_pkg::ACT_END:
                begin
                    push_data.frame_ready  = 1'b1;
                    push_data.frame_length =
                        (total > {2'b00, rfr_pkg::FRAME_LEN_SAT})
                        ? rfr_pkg::FRAME_LEN_SAT : total[rfr_pkg::FRAME_LEN_W-1:0];
                    open_next   = 1'b0;
                    stored_next = '0;
                end
                rfr_pkg::ACT_END_DROP:
                begin
                    push_data.overflow_drop = 1'b1;
                    open_next   = 1'b0;
                    stored_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frag_reg  <= rfr_pkg::MAX_FRAGMENT_LEN_RESET;
            max_frame_reg <= rfr_pkg::MAX_FRAME_LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rfr_pkg::CFG_MAX_FRAGMENT_LEN:
                    max_frag_reg <= cfg_data[rfr_pkg::FRAG_LEN_W-1:0];
                rfr_pkg::CFG_MAX_FRAME_LEN:
                    max_frame_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            stored_reg <= '0;
            idx_reg    <= '0;
            act_reg    <= rfr_pkg::ACT_NONE;
            base_reg   <= '0;
        end
        else if (accept)
        begin
            open_reg   <= open_next;
            stored_reg <= stored_next;
            idx_reg    <= idx_next;
            act_reg    <= act_next;
            base_reg   <= base_next;
        end
    end

endmodule

// ===== hdl/rfr_queue.sv =====
module rfr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  rfr_pkg::work_t  push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output rfr_pkg::work_t  pop_data
);

    rfr_pkg::work_t mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg,  count_next;
    logic           push;
    logic           pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/rfr_back.sv =====
module rfr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  rfr_pkg::work_t     pop_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rfr_pkg::out_item_t out_data
);

    logic [rfr_pkg::CRC_W-1:0] crc_reg, crc_next;
    logic                      out_valid_reg, out_valid_next;
    rfr_pkg::out_item_t        out_reg, out_next;
    logic [rfr_pkg::CRC_W-1:0] crc_new;
    logic                      pop;

    assign pop_ready = !out_valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        crc_new = pop_data.crc_update ? rfr_pkg::crc_byte(crc_reg, pop_data.crc_data)
                                      : crc_reg;
        // running crc restarts after the last item of each fragment
        crc_next = pop_data.fragment_done ? rfr_pkg::CRC_PRESET : crc_new;

        out_next               = '0;
        out_next.write_enable  = pop_data.write_enable;
        out_next.write_address = pop_data.write_address;
        out_next.write_data    = pop_data.write_enable ? pop_data.crc_data : '0;
        out_next.fragment_done = pop_data.fragment_done;
        out_next.crc_error     = pop_data.fragment_done && pop_data.crc_check
                                 && ((~crc_new) != pop_data.expected_crc);
        out_next.length_error  = pop_data.length_error;
        out_next.overflow_drop = pop_data.overflow_drop;
        out_next.frame_ready   = pop_data.frame_ready;
        out_next.frame_length  = pop_data.frame_length;

        out_valid_next = pop ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= rfr_pkg::CRC_PRESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                crc_reg <= crc_next;
            end
        end
    end

endmodule

// ===== hdl/radio_fragment_reassembler.sv =====
// Reassembles radio fragments, at most one payload byte per transfer, into an external frame
// buffer: each input transfer yields exactly one result transfer with the buffer write (address
// and byte), and on the fragment's last byte the CRC-32 check, length error, overflow drop and
// completed frame length. The block takes one byte every cycle while the output is not stalled;
// the front classifies each input combinationally into a two-entry queue, the back pops it into
// the CRC unit and output register, and either side may stall without losing a transfer.
// max_fragment_len (index 0) and max_frame_len (index 1) must be written only while idle; the
// block does not enforce this.
module radio_fragment_reassembler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  rfr_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rfr_pkg::out_item_t             out_data,
    input  logic                           cfg_write,
    input  logic [rfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfr_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic           push_valid;
    logic           push_ready;
    rfr_pkg::work_t push_data;
    logic           pop_valid;
    logic           pop_ready;
    rfr_pkg::work_t pop_data;

    rfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
